// ===== rtl/core/pidaw_pkg.sv =====
// Package for the PID core: microcode format, program store and saturation helpers.
package pidaw_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ProdW   = 2 * (DataW + 1);
  localparam int unsigned DivW    = DataW + 16;
  localparam int unsigned PcW     = 4;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [3:0] {
    OP_ERR,
    OP_MUL,
    OP_LD_PTERM,
    OP_LD_TMP,
    OP_ITERM,
    OP_DZERO,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DTERM,
    OP_SUM,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    MS_PROP,
    MS_INTEG,
    MS_TMP_DT,
    MS_DERIV
  } msel_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_NO_DERIV,
    JC_DIV_BUSY
  } jc_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INTEG = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_TARGET     = 3'd3,
    CFG_CLAMP_LOW  = 3'd4,
    CFG_CLAMP_HIGH = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CS_WITHIN = 2'd0,
    CS_HIGH   = 2'd1,
    CS_LOW    = 2'd2
  } clamp_state_t;

  typedef struct packed {
    op_t             op;
    msel_t           msel;
    jc_t             jc;
    logic [PcW-1:0]  target;
  } ucode_t;

  localparam logic [PcW-1:0] PcSum  = 4'd14;
  localparam logic [PcW-1:0] PcDivS = 4'd12;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_FINISH, msel: MS_PROP, jc: JC_NONE, target: '0};
    case (pc)
      4'd0:  w.op = OP_ERR;
      4'd1:  begin w.op = OP_MUL; w.msel = MS_PROP; end
      4'd2:  w.op = OP_LD_PTERM;
      4'd3:  begin w.op = OP_MUL; w.msel = MS_INTEG; end
      4'd4:  w.op = OP_LD_TMP;
      4'd5:  begin w.op = OP_MUL; w.msel = MS_TMP_DT; end
      4'd6:  w.op = OP_LD_TMP;
      4'd7:  w.op = OP_ITERM;
      4'd8:  begin w.op = OP_DZERO; w.jc = JC_NO_DERIV; w.target = PcSum; end
      4'd9:  begin w.op = OP_MUL; w.msel = MS_DERIV; end
      4'd10: w.op = OP_LD_TMP;
      4'd11: w.op = OP_DIV_INIT;
      4'd12: begin w.op = OP_DIV_STEP; w.jc = JC_DIV_BUSY; w.target = PcDivS; end
      4'd13: w.op = OP_DTERM;
      4'd14: w.op = OP_SUM;
      default: w.op = OP_FINISH;
    endcase
    return w;
  endfunction

  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
    if (v[DataW] != v[DataW-1])
      return v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] v);
    if (v[DataW+1:DataW-1] != {3{v[DataW+1]}})
      return v[DataW+1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    return v[DataW-1:0];
  endfunction

  // floor(p / 2^16), saturated
  function automatic logic signed [DataW-1:0] qsat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> 16;
    if (s[ProdW-1:DataW-1] != {(ProdW-DataW+1){s[ProdW-1]}})
      return s[ProdW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    return s[DataW-1:0];
  endfunction

endpackage

// ===== rtl/core/pid_controller_anti_windup_core.sv =====
// PID controller with conditional-integration anti-windup, microcoded datapath.
//
// Input stream s_*: one command per transfer. tuser carries cmd (0 run a control
// step, 1 clear integral, previous sample and primed flag). A clear starts no run
// and gives no result. A run gives one result on m_*.
// Config channel cfg_*: index selects gain_prop, gain_integ, gain_deriv, target,
// clamp_low, clamp_high (0..5); data is the signed Q16.16 value. Always ready;
// write only while the core is idle.
// Sequencing: a run steps through a 16-word microprogram, one word a cycle, sharing
// one 33x33 multiplier. Without a derivative (first step, or step_time zero) the
// derivative product and divider are skipped and the derivative term is zero;
// otherwise the derivative product is divided by step_time in 48 single-bit
// restoring divider iterations. One run at a time: no command is taken during a run.
// A result waits in the output register until taken; the next command may be
// accepted meanwhile, and a run then holds at its final word while m_tready is low.
// Reset (rst, synchronous) restores register defaults and clears running state.
module pid_controller_anti_windup_core
  import pidaw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,   // [31:0] sample, [63:32] step_time
  input  logic                s_tuser,   // [0] cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // [31:0] drive, [33:32] clamp_state, rest zero
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DataW-1:0]    cfg_data
);

  logic signed [DataW-1:0] gain_prop, gain_integ, gain_deriv, target, clamp_low, clamp_high;
  logic signed [DataW-1:0] integral, last_sample;
  logic                    primed;

  logic                    busy;
  logic [PcW-1:0]          pc;
  logic [PcW-1:0]          pc_next;
  ucode_t                  uw;

  logic signed [DataW-1:0] meas;
  logic [DataW-1:0]        dt;
  logic signed [DataW-1:0] err, diff, pterm, iterm, dterm, tmp, sum;
  logic signed [ProdW-1:0] prod;
  logic signed [DataW:0]   mul_a, mul_b;

  logic [DataW-1:0]        rem;
  logic [DivW-1:0]         dvd;
  logic [DivCntW-1:0]      div_cnt;
  logic                    div_neg;
  logic [DataW:0]          rem_sh;
  logic                    q_bit;
  logic                    jump;
  logic                    out_free;
  logic                    commit;
  logic signed [DataW-1:0] drive_sel;
  clamp_state_t            cs_sel;
  logic signed [DataW-1:0] dterm_sel;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign out_free  = !m_tvalid || m_tready;
  assign uw        = ucode_rom(pc);

  always_comb begin
    case (uw.msel)
      MS_PROP:   begin mul_a = {gain_prop[DataW-1], gain_prop};   mul_b = {err[DataW-1], err}; end
      MS_INTEG:  begin mul_a = {gain_integ[DataW-1], gain_integ}; mul_b = {err[DataW-1], err}; end
      MS_TMP_DT: begin mul_a = {tmp[DataW-1], tmp};               mul_b = {1'b0, dt}; end
      default:   begin mul_a = {gain_deriv[DataW-1], gain_deriv}; mul_b = {diff[DataW-1], diff}; end
    endcase
  end

  assign rem_sh = {rem, dvd[DivW-1]};
  assign q_bit  = rem_sh >= {1'b0, dt};

  always_comb begin
    if (dvd[DivW-1:DataW-1] != '0)
      dterm_sel = div_neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    else if (div_neg)
      dterm_sel = -$signed(dvd[DataW-1:0]);
    else
      dterm_sel = $signed(dvd[DataW-1:0]);
    // quotient of exactly 2^31 with negative sign
    if (div_neg && dvd[DivW-1:DataW] == '0 && dvd[DataW-1])
      dterm_sel = {1'b1, {(DataW-1){1'b0}}};
  end

  always_comb begin
    if (sum > clamp_high) begin
      drive_sel = clamp_high;
      cs_sel    = CS_HIGH;
      commit    = err <= 0;
    end else if (sum < clamp_low) begin
      drive_sel = clamp_low;
      cs_sel    = CS_LOW;
      commit    = err >= 0;
    end else begin
      drive_sel = sum;
      cs_sel    = CS_WITHIN;
      commit    = 1'b1;
    end
  end

  always_comb begin
    case (uw.jc)
      JC_NO_DERIV: jump = !primed || dt == '0;
      JC_DIV_BUSY: jump = div_cnt != '0;
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
      target     <= '0;
      clamp_low  <= {1'b1, {(DataW-1){1'b0}}};
      clamp_high <= {1'b0, {(DataW-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:  gain_prop  <= cfg_data;
        CFG_GAIN_INTEG: gain_integ <= cfg_data;
        CFG_GAIN_DERIV: gain_deriv <= cfg_data;
        CFG_TARGET:     target     <= cfg_data;
        CFG_CLAMP_LOW:  clamp_low  <= cfg_data;
        CFG_CLAMP_HIGH: clamp_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= '0;
      m_tvalid    <= 1'b0;
      integral    <= '0;
      last_sample <= '0;
      primed      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(busy && uw.op == OP_FINISH))
        m_tvalid <= 1'b0;
      if (!busy) begin
        if (s_tvalid) begin
          if (s_tuser) begin
            integral    <= '0;
            last_sample <= '0;
            primed      <= 1'b0;
          end else begin
            busy <= 1'b1;
            pc   <= '0;
          end
        end
      end else if (uw.op == OP_FINISH) begin
        if (out_free) begin
          m_tvalid    <= 1'b1;
          busy        <= 1'b0;
          last_sample <= meas;
          primed      <= 1'b1;
          if (commit)
            integral <= iterm;
        end
      end else begin
        pc <= pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && s_tvalid) begin
      meas <= s_tdata[31:0];
      dt   <= s_tdata[63:32];
    end
    if (busy) begin
      case (uw.op)
        OP_ERR: begin
          err  <= sat33({meas[DataW-1], meas} - {target[DataW-1], target});
          diff <= sat33({meas[DataW-1], meas} - {last_sample[DataW-1], last_sample});
        end
        OP_MUL:      prod  <= mul_a * mul_b;
        OP_LD_PTERM: pterm <= qsat(prod);
        OP_LD_TMP:   tmp   <= qsat(prod);
        OP_ITERM:    iterm <= sat33({integral[DataW-1], integral} + {tmp[DataW-1], tmp});
        OP_DZERO:    dterm <= '0;
        OP_DIV_INIT: begin
          div_neg <= tmp[DataW-1];
          dvd     <= {tmp[DataW-1] ? DataW'(-tmp) : DataW'(tmp), 16'd0};
          rem     <= '0;
          div_cnt <= DivCntW'(DivW - 1);
        end
        OP_DIV_STEP: begin
          rem     <= q_bit ? DataW'(rem_sh - {1'b0, dt}) : rem_sh[DataW-1:0];
          dvd     <= {dvd[DivW-2:0], q_bit};
          div_cnt <= div_cnt - 1'b1;
        end
        OP_DTERM: dterm <= dterm_sel;
        OP_SUM: sum <= sat34({{2{pterm[DataW-1]}}, pterm} + {{2{iterm[DataW-1]}}, iterm}
                             + {{2{dterm[DataW-1]}}, dterm});
        OP_FINISH: begin
          if (out_free)
            m_tdata <= {6'd0, cs_sel, drive_sel};
        end
        default: ;
      endcase
    end
  end

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> busy && pc == '0)
    else $error("run command did not start the sequencer");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !busy && !primed && integral == '0)
    else $error("clear command left running state");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy) && !busy && primed)
    else $error("result without a finished run");

  a_clamp_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'b11)
    else $error("invalid clamp state code");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    busy && uw.op == OP_DIV_STEP |-> dt != '0 && rem < dt)
    else $error("divider remainder out of range");

endmodule
